[sv/tcgr_pkg.sv]
// Shared types, constants and the 5x8 glyph table of the text cursor glyph renderer.
`default_nettype none

package tcgr_pkg;

    // Working width for cursor arithmetic, wide enough for an 11-bit coordinate
    // plus or minus eight times the largest scale.
    localparam int CW         = 13;
    localparam int CELLS      = 48;
    localparam int GLYPH_COLS = 5;
    localparam int CELL_ROWS  = 8;

    typedef logic signed [10:0]   t_coord;
    typedef logic signed [CW-1:0] t_wide;
    typedef logic [15:0]          t_color;
    typedef logic [3:0]           t_scale;
    typedef logic [1:0]           t_cfg_addr;

    localparam t_cfg_addr CFG_TEXT_COLOR       = 2'd0;
    localparam t_cfg_addr CFG_BACKGROUND_COLOR = 2'd1;
    localparam t_cfg_addr CFG_TEXT_SCALE       = 2'd2;

    localparam t_color TEXT_COLOR_RESET = 16'hFFFF;
    localparam t_color BG_COLOR_RESET   = 16'h0000;
    localparam t_scale SCALE_RESET      = 4'd2;
    localparam t_scale SCALE_MIN        = 4'd1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SET   = 1'b1;

    localparam logic [7:0] CHAR_NL = 8'd10;
    localparam logic [7:0] CHAR_CR = 8'd13;

    localparam t_wide ROW_MIN = -13'sd1024;
    localparam t_wide ONE     = 13'sd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRAP,
        S_BOTTOM,
        S_PLACE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic wrap;
        logic bottom;
        logic place;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic draw;
        logic cells_done;
    } t_status;

    // Each entry holds the five column bytes of one glyph, column 0 in the top byte.
    // Bit 0 of a column byte is the top pixel row.
    localparam logic [39:0] GLYPH_TABLE [256] = '{
        40'h0000000000, 40'h3E5B4F5B3E, 40'h3E6B4F6B3E, 40'h1C3E7C3E1C,
        40'h183C7E3C18, 40'h1C577D571C, 40'h1C5E7F5E1C, 40'h00183C1800,
        40'hFFE7C3E7FF, 40'h0018241800, 40'hFFE7DBE7FF, 40'h30483A060E,
        40'h2629792926, 40'h407F050507, 40'h407F05253F, 40'h5A3CE73C5A,
        40'h7F3E1C1C08, 40'h081C1C3E7F, 40'h14227F2214, 40'h5F5F005F5F,
        40'h06097F017F, 40'h006689956A, 40'h6060606060, 40'h94A2FFA294,
        40'h08047E0408, 40'h10207E2010, 40'h08082A1C08, 40'h081C2A0808,
        40'h1E10101010, 40'h0C1E0C1E0C, 40'h30383E3830, 40'h060E3E0E06,
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649562050, 40'h0008070300,
        40'h001C224100, 40'h0041221C00, 40'h2A1C7F1C2A, 40'h08083E0808,
        40'h0080703000, 40'h0808080808, 40'h0000606000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h7249494946, 40'h2141494D33,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494931, 40'h4121110907,
        40'h3649494936, 40'h464949291E, 40'h0000140000, 40'h0040340000,
        40'h0008142241, 40'h1414141414, 40'h0041221408, 40'h0201590906,
        40'h3E415D594E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E41415173,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F021C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h2649494932,
        40'h03017F0103, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0304780403, 40'h6159494D43, 40'h007F414141,
        40'h0204081020, 40'h004141417F, 40'h0402010204, 40'h4040404040,
        40'h0003070800, 40'h2054547840, 40'h7F28444438, 40'h3844444428,
        40'h384444287F, 40'h3854545418, 40'h00087E0902, 40'h18A4A49C78,
        40'h7F08040478, 40'h00447D4000, 40'h2040403D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C04780478, 40'h7C08040478, 40'h3844444438,
        40'hFC18242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545424,
        40'h04043F4424, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h4C9090907C, 40'h4464544C44, 40'h0008364100,
        40'h0000770000, 40'h0041360800, 40'h0201020402, 40'h3C2623263C,
        40'h1EA1A16112, 40'h3A4040207A, 40'h3854545559, 40'h2155557941,
        40'h2254547842, 40'h2155547840, 40'h2054557940, 40'h0C1E527212,
        40'h3955555559, 40'h3954545459, 40'h3955545458, 40'h0000457C41,
        40'h0002457D42, 40'h0001457C40, 40'h7D1211127D, 40'hF0282528F0,
        40'h7C54554500, 40'h2054547C54, 40'h7C0A097F49, 40'h3249494932,
        40'h3A4444443A, 40'h324A484830, 40'h3A4141217A, 40'h3A42402078,
        40'h009DA0A07D, 40'h3D4242423D, 40'h3D4040403D, 40'h3C24FF2424,
        40'h487E494366, 40'h2B2FFC2F2B, 40'hFF0929F620, 40'hC0887E0903,
        40'h2054547941, 40'h0000447D41, 40'h3048484A32, 40'h384040227A,
        40'h007A0A0A72, 40'h7D0D19317D, 40'h2629292F28, 40'h2629292926,
        40'h30484D4020, 40'h3808080808, 40'h0808080838, 40'h2F10C8ACBA,
        40'h2F102834FA, 40'h00007B0000, 40'h08142A1422, 40'h22142A1408,
        40'h5500550055, 40'hAA55AA55AA, 40'hFF55FF55FF, 40'h000000FF00,
        40'h101010FF00, 40'h141414FF00, 40'h1010FF00FF, 40'h1010F010F0,
        40'h141414FC00, 40'h1414F700FF, 40'h0000FF00FF, 40'h1414F404FC,
        40'h141417101F, 40'h10101F101F, 40'h1414141F00, 40'h101010F000,
        40'h0000001F10, 40'h1010101F10, 40'h101010F010, 40'h000000FF10,
        40'h1010101010, 40'h101010FF10, 40'h000000FF14, 40'h0000FF00FF,
        40'h00001F1017, 40'h0000FC04F4, 40'h1414171017, 40'h1414F404F4,
        40'h0000FF00F7, 40'h1414141414, 40'h1414F700F7, 40'h1414141714,
        40'h10101F101F, 40'h141414F414, 40'h1010F010F0, 40'h00001F101F,
        40'h0000001F14, 40'h000000FC14, 40'h0000F010F0, 40'h1010FF10FF,
        40'h141414FF14, 40'h1010101F00, 40'h000000F010, 40'hFFFFFFFFFF,
        40'hF0F0F0F0F0, 40'hFFFFFF0000, 40'h000000FFFF, 40'h0F0F0F0F0F,
        40'h3844443844, 40'hFC4A4A4A34, 40'h7E02020606, 40'h027E027E02,
        40'h6355494163, 40'h3844443C04, 40'h407E201E20, 40'h06027E0202,
        40'h99A5E7A599, 40'h1C2A492A1C, 40'h4C7201724C, 40'h304A4D4D30,
        40'h3048784830, 40'hBC625A463D, 40'h3E49494900, 40'h7E0101017E,
        40'h2A2A2A2A2A, 40'h44445F4444, 40'h40514A4440, 40'h40444A5140,
        40'h0000FF0103, 40'hE080FF0000, 40'h08086B6B08, 40'h3612362436,
        40'h060F090F06, 40'h0000181800, 40'h0000101000, 40'h3040FF0101,
        40'h001F01011E, 40'h00191D1712, 40'h003C3C3C3C, 40'h0000000000
    };

endpackage

`default_nettype wire

[sv/text_cursor_glyph_renderer.sv]
// Top level: a character or a cursor command goes in, one beat per square fill comes out.
// Cursor set, newline and carriage return are taken while idle and give no beat.
// A drawn character passes the wrap, bottom and placement states, then walks at most 48 cells,
// one per cycle while the output is not stalled; fills go to the output register during this walk.
// The walk ends early when no cell with a fill is left.
// Synchronous reset clears cursor, sequencer and output valid and loads register defaults.
`default_nettype none

module text_cursor_glyph_renderer #(
    parameter int DISPLAY_WIDTH  = 480,
    parameter int DISPLAY_HEIGHT = 320,
    parameter int GLYPH_COUNT    = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  tcgr_pkg::t_cfg_addr  i_cfg_addr,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_command,
    input  logic [7:0]           i_char_code,
    input  logic signed [10:0]   i_new_x,
    input  logic signed [10:0]   i_new_y,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [10:0]   o_rect_x,
    output logic signed [10:0]   o_rect_y,
    output logic [3:0]           o_rect_side,
    output logic [15:0]          o_rect_color,
    output logic                 o_last
);
    import tcgr_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    tcgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tcgr_datapath #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
        .GLYPH_COUNT    (GLYPH_COUNT)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_command    (i_command),
        .i_char_code  (i_char_code),
        .i_new_x      (i_new_x),
        .i_new_y      (i_new_y),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_rect_x     (o_rect_x),
        .o_rect_y     (o_rect_y),
        .o_rect_side  (o_rect_side),
        .o_rect_color (o_rect_color),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

[sv/tcgr_ctrl.sv]
// Controller state machine: sequences cursor update, placement and fill emission.
`default_nettype none

module tcgr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tcgr_pkg::t_status i_status,
    output tcgr_pkg::t_cmd    o_cmd
);
    import tcgr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    // Cursor commands, newline and carriage return finish in this beat.
                    if (i_status.draw) begin
                        n_state = S_WRAP;
                    end
                end
            end
            S_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_state    = S_BOTTOM;
            end
            S_BOTTOM: begin
                o_cmd.bottom = 1'b1;
                n_state      = S_PLACE;
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.cells_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/tcgr_datapath.sv]
// Datapath: configuration registers, cursor arithmetic, glyph cell walk and output register.
`default_nettype none

module tcgr_datapath #(
    parameter int DISPLAY_WIDTH  = 480,
    parameter int DISPLAY_HEIGHT = 320,
    parameter int GLYPH_COUNT    = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  tcgr_pkg::t_cfg_addr   i_cfg_addr,
    input  logic [15:0]           i_cfg_data,
    input  logic                  i_command,
    input  logic [7:0]            i_char_code,
    input  logic signed [10:0]    i_new_x,
    input  logic signed [10:0]    i_new_y,
    input  tcgr_pkg::t_cmd        i_cmd,
    output tcgr_pkg::t_status     o_status,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic signed [10:0]    o_rect_x,
    output logic signed [10:0]    o_rect_y,
    output logic [3:0]            o_rect_side,
    output logic [15:0]           o_rect_color,
    output logic                  o_last
);
    import tcgr_pkg::*;

    localparam t_wide W_LIM = t_wide'(DISPLAY_WIDTH);
    localparam t_wide H_LIM = t_wide'(DISPLAY_HEIGHT);
    localparam t_wide H_TOP = t_wide'(DISPLAY_HEIGHT - 1);
    localparam logic [2:0] LAST_ROW = 3'(CELL_ROWS - 1);

    // Configuration.
    t_color r_text_color;
    t_color r_bg_color;
    t_scale r_scale;

    // Cursor.
    t_coord r_col;
    t_coord r_row;
    t_coord n_col;
    t_coord n_row;

    // Cell walk.
    logic [CELLS-1:0] r_pix;
    logic [CELLS-1:0] r_mask;
    logic [CELLS-1:0] n_pix;
    logic [CELLS-1:0] n_mask;
    logic [CELLS-1:0] w_cells;
    logic [39:0]      w_glyph;
    logic             w_known;
    t_wide            r_x_cell;
    t_wide            r_y_cell;
    t_wide            r_y_top;
    logic [2:0]       r_row_idx;

    // Output register.
    logic             r_out_valid;
    t_coord           r_out_x;
    t_coord           r_out_y;
    t_scale           r_out_side;
    t_color           r_out_color;
    logic             r_out_last;

    t_wide w_col;
    t_wide w_row;
    t_wide w_sw;
    t_wide w_s6;
    t_wide w_s8;
    t_wide w_row_dn;
    t_wide w_row_sat;
    t_wide w_col_adv;
    t_wide w_y_first;
    logic  w_edge;
    logic  w_bottom;
    logic  w_visible;
    logic  w_adv;
    logic  w_load_beat;
    logic  w_beat_last;

    assign w_col = t_wide'(r_col);
    assign w_row = t_wide'(r_row);
    assign w_sw  = t_wide'(r_scale);
    assign w_s6  = t_wide'({r_scale, 2'b00}) + t_wide'({r_scale, 1'b0});
    assign w_s8  = t_wide'({r_scale, 3'b000});

    assign w_row_dn  = w_row - w_s8;
    assign w_row_sat = (w_row_dn < ROW_MIN) ? ROW_MIN : w_row_dn;
    assign w_col_adv = w_col + w_s6;
    assign w_edge    = w_col_adv > W_LIM;
    assign w_bottom  = w_row < w_s6;
    assign w_visible = !((w_col >= W_LIM) || (w_row >= H_LIM) ||
                         (w_col_adv < ONE) || ((w_row + w_s8) < ONE));
    assign w_y_first = w_row - w_sw + ONE;

    assign o_status.draw = (i_command == CMD_WRITE) && (i_char_code != CHAR_NL) &&
                           (i_char_code != CHAR_CR);
    assign o_status.cells_done = (r_mask == '0);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= TEXT_COLOR_RESET;
            r_bg_color   <= BG_COLOR_RESET;
            r_scale      <= SCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_TEXT_COLOR:       r_text_color <= i_cfg_data;
                CFG_BACKGROUND_COLOR: r_bg_color   <= i_cfg_data;
                CFG_TEXT_SCALE: begin
                    r_scale <= (i_cfg_data[3:0] == '0) ? SCALE_MIN : i_cfg_data[3:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Cursor update, one step per controller command.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cmd.load) begin
            if (i_command == CMD_SET) begin
                n_col = i_new_x;
                n_row = i_new_y;
            end else if (i_char_code == CHAR_NL) begin
                n_col = '0;
                n_row = w_row_sat[10:0];
            end
        end else if (i_cmd.wrap) begin
            if (w_edge) begin
                n_col = '0;
                n_row = w_row_sat[10:0];
            end
        end else if (i_cmd.bottom) begin
            if (w_bottom) begin
                n_col = '0;
                n_row = H_TOP[10:0];
            end
        end else if (i_cmd.place) begin
            n_col = w_col_adv[10:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Unpack the glyph into 48 cells, eight rows per column; the sixth column stays blank.
    assign w_glyph = GLYPH_TABLE[i_char_code];
    assign w_known = {1'b0, i_char_code} < 9'(GLYPH_COUNT);

    always_comb begin
        w_cells = '0;
        for (int c = 0; c < GLYPH_COLS; c++) begin
            w_cells[c*CELL_ROWS +: CELL_ROWS] = w_glyph[39 - c*CELL_ROWS -: CELL_ROWS];
        end
        if (!w_known) begin
            w_cells = '0;
        end
    end

    assign w_adv       = i_cmd.emit && (!r_out_valid || i_out_ready);
    assign w_load_beat = w_adv && r_mask[0];
    assign w_beat_last = (r_mask[CELLS-1:1] == '0);

    // A visible cell produces a fill when its pixel is set, or always when the colors differ.
    always_comb begin
        n_pix  = r_pix;
        n_mask = r_mask;
        if (i_cmd.load) begin
            n_pix = w_cells;
        end else if (i_cmd.place) begin
            if (!w_visible) begin
                n_mask = '0;
            end else if (r_text_color == r_bg_color) begin
                n_mask = r_pix;
            end else begin
                n_mask = '1;
            end
        end else if (w_adv) begin
            n_pix  = r_pix >> 1;
            n_mask = r_mask >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix <= n_pix;
        if (i_cmd.place) begin
            r_x_cell  <= w_col;
            r_y_top   <= w_y_first;
            r_y_cell  <= w_y_first;
            r_row_idx <= '0;
        end else if (w_adv) begin
            if (r_row_idx == LAST_ROW) begin
                r_row_idx <= '0;
                r_x_cell  <= r_x_cell + w_sw;
                r_y_cell  <= r_y_top;
            end else begin
                r_row_idx <= r_row_idx + 3'd1;
                r_y_cell  <= r_y_cell - w_sw;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_beat) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_beat) begin
            r_out_x     <= r_x_cell[10:0];
            r_out_y     <= r_y_cell[10:0];
            r_out_side  <= r_scale;
            r_out_color <= r_pix[0] ? r_text_color : r_bg_color;
            r_out_last  <= w_beat_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_rect_x     = r_out_x;
    assign o_rect_y     = r_out_y;
    assign o_rect_side  = r_out_side;
    assign o_rect_color = r_out_color;
    assign o_last       = r_out_last;

    a_scale_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scale != '0)
        else $error("text scale register holds zero");

    a_load_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (r_mask == '0))
        else $error("new character taken while cells remain");

    a_last_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_beat && w_beat_last) |=> (r_mask == '0))
        else $error("cells remain after the final beat");

    a_beat_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_beat |=> r_out_valid)
        else $error("loaded beat not presented");

endmodule

`default_nettype wire
